### src/vmvp_pkg.sv
package vmvp_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int SIZE_W    = 13;
    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);

    // Operands carry one extra bit so the viewport term (1 + c) fits unclipped.
    localparam int OPND_W    = WORD_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    // Four floored products of a matrix row, summed exactly.
    localparam int MAT_SUM_W = 2 * WORD_W - FRAC_BITS + 2;
    // (1 + c) times a 13-bit scale, halved.
    localparam int VP_SUM_W  = OPND_W + SIZE_W + 2;
    localparam int ACC_W     = (MAT_SUM_W > VP_SUM_W) ? MAT_SUM_W : VP_SUM_W;

    // Operation schedule: 16 model MACs, 16 projection MACs, 3 viewport products.
    localparam int NUM_MAT_OPS = 2 * ENTRIES;
    localparam int NUM_VP_OPS  = 3;
    localparam int NUM_OPS     = NUM_MAT_OPS + NUM_VP_OPS;
    localparam int PIPE_DRAIN  = 2;
    localparam int STEP_LAST   = NUM_OPS + PIPE_DRAIN - 1;
    localparam int STEP_W      = $clog2(STEP_LAST + 1);

    localparam logic [WORD_W-1:0] FIX_ONE = WORD_W'(1) << FRAC_BITS;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    localparam int S_TDATA_W = 296;
    localparam int M_TDATA_W = 288;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        FN_LOAD_MODEL = 2'd0,
        FN_LOAD_PROJ  = 2'd1,
        FN_VERTEX     = 2'd2,
        FN_COMMAND    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    localparam logic KIND_VERTEX  = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    localparam logic SEL_MODEL = 1'b0;
    localparam logic SEL_PROJ  = 1'b1;

    typedef struct packed {
        logic       is_vp;
        logic       stage;
        logic [1:0] row;
        logic       first;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic              valid;
        t_tag              tag;
        logic [WORD_W-1:0] value;
    } t_mac_res;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] identity_entry(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] r;
        r = (idx[3:2] == idx[1:0]) ? FIX_ONE : '0;
        return r;
    endfunction

endpackage

### src/vmvp_mstore.sv
module vmvp_mstore (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic                             i_wsel,
    input  logic [vmvp_pkg::IDX_W-1:0]       i_widx,
    input  logic [vmvp_pkg::WORD_W-1:0]      i_wdata,
    input  logic                             i_rsel,
    input  logic [vmvp_pkg::IDX_W-1:0]       i_ridx,
    output logic [vmvp_pkg::WORD_W-1:0]      o_rdata
);

    logic [vmvp_pkg::WORD_W-1:0] r_model [vmvp_pkg::ENTRIES];
    logic [vmvp_pkg::WORD_W-1:0] r_proj  [vmvp_pkg::ENTRIES];

    // Both matrices come out of reset as identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vmvp_pkg::ENTRIES; i++) begin
                r_model[i] <= vmvp_pkg::identity_entry(vmvp_pkg::IDX_W'(i));
                r_proj[i]  <= vmvp_pkg::identity_entry(vmvp_pkg::IDX_W'(i));
            end
        end else if (i_we) begin
            if (i_wsel == vmvp_pkg::SEL_PROJ) begin
                r_proj[i_widx] <= i_wdata;
            end else begin
                r_model[i_widx] <= i_wdata;
            end
        end
    end

    assign o_rdata = (i_rsel == vmvp_pkg::SEL_PROJ) ? r_proj[i_ridx] : r_model[i_ridx];

endmodule

### src/vmvp_mac.sv
module vmvp_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_issue,
    input  logic [vmvp_pkg::OPND_W-1:0]      i_opa,
    input  logic [vmvp_pkg::OPND_W-1:0]      i_opb,
    input  vmvp_pkg::t_tag                   i_tag,
    output vmvp_pkg::t_mac_res               o_res
);

    logic                                 r_v1;
    logic                                 r_v2;
    logic signed [vmvp_pkg::OPND_W-1:0]   r_opa;
    logic signed [vmvp_pkg::OPND_W-1:0]   r_opb;
    vmvp_pkg::t_tag                       r_tag1;
    vmvp_pkg::t_tag                       r_tag2;
    logic signed [vmvp_pkg::PROD_W-1:0]   r_prod;
    logic signed [vmvp_pkg::ACC_W-1:0]    r_acc;

    logic signed [vmvp_pkg::PROD_W-1:0]   w_shift_full;
    logic signed [vmvp_pkg::ACC_W-1:0]    w_shift;
    logic signed [vmvp_pkg::ACC_W-1:0]    w_base;
    logic signed [vmvp_pkg::ACC_W-1:0]    w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    // Operand register, product register, then accumulate.
    always_ff @(posedge i_clk) begin
        r_opa  <= i_opa;
        r_opb  <= i_opb;
        r_tag1 <= i_tag;
        r_prod <= r_opa * r_opb;
        r_tag2 <= r_tag1;
        if (r_v2) begin
            r_acc <= w_sum;
        end
    end

    // Arithmetic shifts floor toward minus infinity.
    always_comb begin
        w_shift_full = r_tag2.is_vp ? (r_prod >>> 1) : (r_prod >>> vmvp_pkg::FRAC_BITS);
        w_shift      = w_shift_full[vmvp_pkg::ACC_W-1:0];
        w_base       = r_tag2.first ? '0 : r_acc;
        w_sum        = w_base + w_shift;
    end

    assign o_res.valid = r_v2 && r_tag2.last;
    assign o_res.tag   = r_tag2;
    assign o_res.value = vmvp_pkg::sat_word(w_sum);

endmodule

### src/vertex_mvp_viewport_transform.sv
// Vertex geometry stage: model matrix, projection matrix and viewport mapping in signed
// Q16.16. A load item (func 0 model, func 1 projection) writes one matrix entry in the
// cycle it is accepted and gives no result. A command item (func 3) goes through the
// done state into the output register. A vertex item (func 2) runs 35 products through
// one shared 33x33 signed multiplier (16 model MACs, 16 projection MACs, 3 viewport
// scales) behind a three-register pipe, so the input stays busy through the accept, the
// sequencer steps (35 issues plus pipe drain) and the hand-off into the output
// register. A finished result waits in that register while the next item is accepted;
// a vertex or command finishing while it is still full holds until it drains.
// Viewport: x = (1+x)/2*(width-1), y = (1+y)/2*(height-1), z = (1+z)/2, w passed on;
// a zero width or height gives a scale of 0. Matrices reset to identity, the screen
// to 640x480. Write screen registers only while the block is idle.
module vertex_mvp_viewport_transform (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [vmvp_pkg::SIZE_W-1:0]          i_cfg_wdata,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index[3:0], coeff_value[35:4], pos_x[67:36], pos_y[99:68],
    // pos_z[131:100], color_r[163:132], color_g[195:164], color_b[227:196],
    // color_a[259:228], command_word[291:260], zero pad[295:292]
    input  logic [vmvp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // func[1:0]
    input  logic [vmvp_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // command_out[31:0], screen_x[63:32], screen_y[95:64], depth[127:96],
    // clip_w[159:128], out_color_r[191:160], out_color_g[223:192],
    // out_color_b[255:224], out_color_a[287:256]
    output logic [vmvp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // result_kind[0]
    output logic [vmvp_pkg::M_TUSER_W-1:0]       m_axis_tuser
);

    localparam int W = vmvp_pkg::WORD_W;

    // ---------------- input unpack ----------------
    vmvp_pkg::t_func                 w_in_func;
    logic [vmvp_pkg::IDX_W-1:0]      w_in_idx;
    logic [W-1:0]                    w_in_coeff;
    logic [W-1:0]                    w_in_pos   [3];
    logic [W-1:0]                    w_in_color [4];
    logic [W-1:0]                    w_in_cmd;

    assign w_in_func     = vmvp_pkg::t_func'(s_axis_tuser[1:0]);
    assign w_in_idx      = s_axis_tdata[3:0];
    assign w_in_coeff    = s_axis_tdata[35:4];
    assign w_in_pos[0]   = s_axis_tdata[67:36];
    assign w_in_pos[1]   = s_axis_tdata[99:68];
    assign w_in_pos[2]   = s_axis_tdata[131:100];
    assign w_in_color[0] = s_axis_tdata[163:132];
    assign w_in_color[1] = s_axis_tdata[195:164];
    assign w_in_color[2] = s_axis_tdata[227:196];
    assign w_in_color[3] = s_axis_tdata[259:228];
    assign w_in_cmd      = s_axis_tdata[291:260];

    // ---------------- state ----------------
    vmvp_pkg::t_state                r_state;
    vmvp_pkg::t_state                n_state;
    logic [vmvp_pkg::STEP_W-1:0]     r_step;
    logic [vmvp_pkg::STEP_W-1:0]     n_step;
    logic                            w_acc;
    logic                            w_load_out;

    vmvp_pkg::t_func                 r_func;
    logic [W-1:0]                    r_pos   [3];
    logic [W-1:0]                    r_color [4];
    logic [W-1:0]                    r_cmd;
    logic [W-1:0]                    r_mvec  [4];
    logic [W-1:0]                    r_pvec  [4];
    logic [W-1:0]                    r_sx;
    logic [W-1:0]                    r_sy;
    logic [W-1:0]                    r_dep;
    logic [vmvp_pkg::SIZE_W-1:0]     r_width;
    logic [vmvp_pkg::SIZE_W-1:0]     r_height;

    logic                            r_ovalid;
    logic                            r_okind;
    logic [W-1:0]                    r_ocmd;
    logic [W-1:0]                    r_osx;
    logic [W-1:0]                    r_osy;
    logic [W-1:0]                    r_odep;
    logic [W-1:0]                    r_ow;
    logic [W-1:0]                    r_ocolor [4];

    assign s_axis_tready = (r_state == vmvp_pkg::ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= vmvp_pkg::WIDTH_RESET;
            r_height <= vmvp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (vmvp_pkg::t_cfg_reg'(i_cfg_index))
                vmvp_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata;
                vmvp_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- matrix store ----------------
    logic                            w_store_we;
    logic [W-1:0]                    w_store_rdata;
    logic                            w_is_vp;
    logic                            w_stage;
    logic [1:0]                      w_row;
    logic [1:0]                      w_col;

    assign w_store_we = w_acc && (w_in_func == vmvp_pkg::FN_LOAD_MODEL ||
                                  w_in_func == vmvp_pkg::FN_LOAD_PROJ);

    vmvp_mstore u_mstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_store_we),
        .i_wsel  (w_in_func == vmvp_pkg::FN_LOAD_PROJ),
        .i_widx  (w_in_idx),
        .i_wdata (w_in_coeff),
        .i_rsel  (w_stage),
        .i_ridx  (r_step[3:0]),
        .o_rdata (w_store_rdata)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmvp_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        w_load_out = 1'b0;
        unique case (r_state)
            vmvp_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (w_in_func == vmvp_pkg::FN_VERTEX) begin
                        n_state = vmvp_pkg::ST_RUN;
                        n_step  = '0;
                    end else if (w_in_func == vmvp_pkg::FN_COMMAND) begin
                        n_state = vmvp_pkg::ST_DONE;
                    end
                end
            end
            vmvp_pkg::ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == vmvp_pkg::STEP_W'(vmvp_pkg::STEP_LAST)) begin
                    n_state = vmvp_pkg::ST_DONE;
                end
            end
            vmvp_pkg::ST_DONE: begin
                // Hand off only when the output register is free or draining.
                if (!r_ovalid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = vmvp_pkg::ST_IDLE;
                end
            end
            default: n_state = vmvp_pkg::ST_IDLE;
        endcase
    end

    // Latch the item's passthrough fields and position on accept.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func <= w_in_func;
            r_pos  <= w_in_pos;
            r_color <= w_in_color;
            r_cmd  <= w_in_cmd;
        end
    end

    // ---------------- operand select ----------------
    // Steps 0-15 model row/col, 16-31 projection row/col, 32-34 viewport x, y, z.
    logic                            w_issue;
    logic [W-1:0]                    w_vin [4];
    logic [W-1:0]                    w_vec_sel;
    logic [vmvp_pkg::SIZE_W-1:0]     w_scale;
    logic [vmvp_pkg::OPND_W-1:0]     w_opa;
    logic [vmvp_pkg::OPND_W-1:0]     w_opb;
    vmvp_pkg::t_tag                  w_tag;
    vmvp_pkg::t_mac_res              w_res;

    assign w_issue = (r_state == vmvp_pkg::ST_RUN) &&
                     (r_step < vmvp_pkg::STEP_W'(vmvp_pkg::NUM_OPS));
    assign w_is_vp = (r_step >= vmvp_pkg::STEP_W'(vmvp_pkg::NUM_MAT_OPS));
    assign w_stage = r_step[4];
    assign w_row   = w_is_vp ? r_step[1:0] : r_step[3:2];
    assign w_col   = r_step[1:0];

    assign w_vin[0] = r_pos[0];
    assign w_vin[1] = r_pos[1];
    assign w_vin[2] = r_pos[2];
    assign w_vin[3] = vmvp_pkg::FIX_ONE;

    always_comb begin
        w_vec_sel = (w_stage == vmvp_pkg::SEL_PROJ) ? r_mvec[w_col] : w_vin[w_col];

        unique case (w_row)
            2'd0:    w_scale = (r_width  != '0) ? r_width  - 1'b1 : '0;
            2'd1:    w_scale = (r_height != '0) ? r_height - 1'b1 : '0;
            2'd2:    w_scale = vmvp_pkg::SIZE_W'(1);
            default: w_scale = '0;
        endcase

        if (w_is_vp) begin
            w_opa = {r_pvec[w_row][W-1], r_pvec[w_row]} + {1'b0, vmvp_pkg::FIX_ONE};
            w_opb = {{(vmvp_pkg::OPND_W-vmvp_pkg::SIZE_W){1'b0}}, w_scale};
        end else begin
            w_opa = {w_store_rdata[W-1], w_store_rdata};
            w_opb = {w_vec_sel[W-1], w_vec_sel};
        end

        w_tag.is_vp = w_is_vp;
        w_tag.stage = w_stage;
        w_tag.row   = w_row;
        w_tag.first = w_is_vp || (w_col == 2'd0);
        w_tag.last  = w_is_vp || (w_col == 2'd3);
    end

    vmvp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .i_tag   (w_tag),
        .o_res   (w_res)
    );

    // Store each finished row or viewport value where later steps pick it up.
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            if (w_res.tag.is_vp) begin
                unique case (w_res.tag.row)
                    2'd0:    r_sx  <= w_res.value;
                    2'd1:    r_sy  <= w_res.value;
                    default: r_dep <= w_res.value;
                endcase
            end else if (w_res.tag.stage == vmvp_pkg::SEL_PROJ) begin
                r_pvec[w_res.tag.row] <= w_res.value;
            end else begin
                r_mvec[w_res.tag.row] <= w_res.value;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_func == vmvp_pkg::FN_COMMAND) begin
                r_okind  <= vmvp_pkg::KIND_COMMAND;
                r_ocmd   <= r_cmd;
                r_osx    <= '0;
                r_osy    <= '0;
                r_odep   <= '0;
                r_ow     <= '0;
                r_ocolor <= '{default: '0};
            end else begin
                r_okind  <= vmvp_pkg::KIND_VERTEX;
                r_ocmd   <= '0;
                r_osx    <= r_sx;
                r_osy    <= r_sy;
                r_odep   <= r_dep;
                r_ow     <= r_pvec[3];
                r_ocolor <= r_color;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {r_ocolor[3], r_ocolor[2], r_ocolor[1], r_ocolor[0],
                            r_ow, r_odep, r_osy, r_osx, r_ocmd};

endmodule
